FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the digitizer event deframer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define DFR_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  `DFR_ASSERT(lbl, clk, rstn, (ante) |-> (cons), msg)

// A consequence that must hold in the cycle after its antecedent.
`define DFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  `DFR_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

FILE: rtl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Types, codes and constants shared by the digitizer event deframer files.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

  // Default upper bound on the sample words of one event.
  localparam int MaxSamplesDef = 1024;

  // Configuration register width and its reset value.
  localparam int CfgW = 11;
  localparam logic [CfgW-1:0] CfgReset = 11'd1024;

  // A stream word of all ones always opens a header.
  localparam logic [31:0] HeaderWord = 32'hFFFF_FFFF;

  // Word position codes: before any header, header words, then data.
  localparam logic [3:0] PosIdle   = 4'd0;
  localparam logic [3:0] PosTsLo   = 4'd1;
  localparam logic [3:0] PosTsHi   = 4'd2;
  localparam logic [3:0] PosIcnt   = 4'd3;
  localparam logic [3:0] PosEvnum  = 4'd6;
  localparam logic [3:0] PosFiller = 4'd7;
  localparam logic [3:0] PosData   = 4'd8;

  typedef enum logic {
    CMD_WORD  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    QUAL_OK      = 2'd0,
    QUAL_ZERO    = 2'd1,
    QUAL_MISSING = 2'd2
  } qual_e;

  // One result beat as it leaves the core.
  typedef struct packed {
    kind_e        kind;
    logic [9:0]   sample_index;
    logic [15:0]  ch0_sample;
    logic [15:0]  ch1_sample;
    logic [63:0]  timestamp;
    logic [31:0]  internal_count;
    logic [31:0]  event_number;
    logic [10:0]  sample_count;
    qual_e        quality_flag;
    logic         overflow;
  } dfr_result_t;

endpackage

`default_nettype wire

FILE: rtl/dfr_channels.sv
// ----------------------------------------------------------------------------
// dfr_channels
// Valid/ready channels of the deframer: stream input, result output and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] word;

  modport source (output valid, output cmd, output word, input ready);
  modport sink   (input valid, input cmd, input word, output ready);
endinterface

interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [9:0]  sample_index;
  logic [15:0] ch0_sample;
  logic [15:0] ch1_sample;
  logic [63:0] timestamp;
  logic [31:0] internal_count;
  logic [31:0] event_number;
  logic [10:0] sample_count;
  logic [1:0]  quality_flag;
  logic        overflow;

  modport source (output valid, output kind, output sample_index, output ch0_sample,
                  output ch1_sample, output timestamp, output internal_count,
                  output event_number, output sample_count, output quality_flag,
                  output overflow, input ready);
  modport sink   (input valid, input kind, input sample_index, input ch0_sample,
                  input ch1_sample, input timestamp, input internal_count,
                  input event_number, input sample_count, input quality_flag,
                  input overflow, output ready);
endinterface

interface dfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] samples_expected;

  modport source (output valid, output samples_expected, input ready);
  modport sink   (input valid, input samples_expected, output ready);
endinterface

`default_nettype wire

FILE: rtl/dfr_core.sv
// ----------------------------------------------------------------------------
// dfr_core
// Event state of the deframer: word position, sample count, quality flags
// and header fields, with the result for the item being consumed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dfr_core #(
  parameter int MAX_SAMPLES = dfr_pkg::MaxSamplesDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [10:0]          samples_expected_i,
  input  wire logic                 adv_i,
  input  wire logic                 cmd_i,
  input  wire logic [31:0]          word_i,
  output logic                      gen_o,
  output dfr_pkg::dfr_result_t      res_o
);
  import dfr_pkg::*;

  // The register is 11 bits wide, so the usable bound never passes 2047.
  localparam logic [10:0] MaxClamp =
      (MAX_SAMPLES > 2047) ? 11'd2047 : 11'(MAX_SAMPLES);
  localparam int CntW = $clog2(int'(MaxClamp) + 1);

  logic [3:0]      pos_q, pos_d;
  logic [CntW-1:0] stored_q, stored_d;
  logic            zero_q, zero_d;
  logic            excess_q, excess_d;
  logic [31:0]     ts_lo_q, ts_lo_d;
  logic [63:0]     ev_time_q, ev_time_d;
  logic [31:0]     icnt_q, icnt_d;
  logic [31:0]     ev_id_q, ev_id_d;
  logic            ev_seen_q, ev_seen_d;

  logic [10:0]     expected;
  logic [10:0]     stored_ext;
  logic            missing;
  dfr_result_t     summ;
  dfr_result_t     res;
  logic            gen;
  logic [15:0]     lo, hi;

  // Expected count, clamped to one and the parameter bound.
  always_comb begin
    if (samples_expected_i == 11'd0) begin
      expected = 11'd1;
    end else if (samples_expected_i > MaxClamp) begin
      expected = MaxClamp;
    end else begin
      expected = samples_expected_i;
    end
  end

  assign stored_ext = 11'(stored_q);
  assign missing    = stored_ext < expected;
  assign lo         = word_i[15:0];
  assign hi         = word_i[31:16];

  // Summary of the event gathered so far.
  always_comb begin
    summ                = '0;
    summ.kind           = KIND_SUMMARY;
    summ.timestamp      = ev_time_q;
    summ.internal_count = icnt_q;
    summ.event_number   = ev_id_q;
    summ.sample_count   = stored_ext;
    summ.overflow       = excess_q;
    if (missing) begin
      summ.quality_flag = QUAL_MISSING;
    end else if (zero_q) begin
      summ.quality_flag = QUAL_ZERO;
    end else begin
      summ.quality_flag = QUAL_OK;
    end
  end

  // Decode of the item and the next event state.
  always_comb begin
    pos_d     = pos_q;
    stored_d  = stored_q;
    zero_d    = zero_q;
    excess_d  = excess_q;
    ts_lo_d   = ts_lo_q;
    ev_time_d = ev_time_q;
    icnt_d    = icnt_q;
    ev_id_d   = ev_id_q;
    ev_seen_d = ev_seen_q;
    gen       = 1'b0;
    res       = '0;
    res.kind  = KIND_SAMPLE;

    priority if (cmd_i == CMD_FLUSH) begin
      // End of stream: always summarise, then start afresh.
      gen       = 1'b1;
      res       = summ;
      stored_d  = '0;
      zero_d    = 1'b0;
      excess_d  = 1'b0;
      ev_time_d = '0;
      pos_d     = PosIdle;
    end else if (word_i == HeaderWord) begin
      // A header closes the previous event only if one was seen.
      if (ev_seen_q) begin
        gen       = 1'b1;
        res       = summ;
        stored_d  = '0;
        zero_d    = 1'b0;
        excess_d  = 1'b0;
        ev_time_d = '0;
      end
      pos_d = PosTsLo;
    end else if (pos_q >= PosTsLo && pos_q <= PosFiller) begin
      // Header words: capture the fields that matter.
      unique case (pos_q)
        PosTsLo:  ts_lo_d = word_i;
        PosTsHi:  ev_time_d = {word_i, ts_lo_q};
        PosIcnt:  icnt_d = word_i;
        PosEvnum: begin
          ev_id_d   = word_i;
          ev_seen_d = 1'b1;
        end
        default: ;
      endcase
      pos_d = pos_q + 4'd1;
    end else begin
      // Data word: store it while room remains, otherwise drop and flag it.
      gen            = 1'b1;
      res.ch0_sample = lo;
      res.ch1_sample = hi;
      if (missing) begin
        res.sample_index = stored_ext[9:0];
        if (lo == 16'd0 || hi == 16'd0) begin
          zero_d = 1'b1;
        end
        stored_d = stored_q + CntW'(1);
      end else begin
        excess_d     = 1'b1;
        res.overflow = 1'b1;
      end
    end
  end

  assign gen_o = gen;
  assign res_o = res;

  // State registers, updated only when the item is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= PosIdle;
      stored_q  <= '0;
      zero_q    <= 1'b0;
      excess_q  <= 1'b0;
      ts_lo_q   <= '0;
      ev_time_q <= '0;
      icnt_q    <= '0;
      ev_id_q   <= '0;
      ev_seen_q <= 1'b0;
    end else if (adv_i) begin
      pos_q     <= pos_d;
      stored_q  <= stored_d;
      zero_q    <= zero_d;
      excess_q  <= excess_d;
      ts_lo_q   <= ts_lo_d;
      ev_time_q <= ev_time_d;
      icnt_q    <= icnt_d;
      ev_id_q   <= ev_id_d;
      ev_seen_q <= ev_seen_d;
    end
  end

  `DFR_ASSERT(a_pos_range, clk_i, rst_ni, pos_q <= PosData, "word position out of range")
  `DFR_ASSERT_IMPL(a_flush_gen, clk_i, rst_ni, adv_i && cmd_i == CMD_FLUSH, gen_o, "flush gave no summary")
  `DFR_ASSERT_NEXT(a_flush_clear, clk_i, rst_ni, adv_i && cmd_i == CMD_FLUSH, pos_q == PosIdle && stored_q == '0 && !excess_q, "flush did not clear the event")

endmodule

`default_nettype wire

FILE: rtl/digitizer_event_deframer.sv
// ----------------------------------------------------------------------------
// digitizer_event_deframer
// Splits a digitizer word stream into sample pair results and event summaries.
// ----------------------------------------------------------------------------
// The block accepts one beat per clock cycle and gives at most one result per
// beat, shown on the output channel from the output register. A beat is
// held in an input register, decoded against the event state by a short path
// of logic, and its result is placed in an output register; the input side
// keeps accepting while a finished result waits there, and stalls only when
// that register is still full and the waiting beat would produce a result.
// The expected sample count is written through the configuration channel,
// which is always ready, and should be changed only while the block is idle.
`default_nettype none
`include "assert_macros.svh"

module digitizer_event_deframer #(
  parameter int MAX_SAMPLES = dfr_pkg::MaxSamplesDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dfr_cfg_if.sink    cfg_i,
  dfr_in_if.sink     in_i,
  dfr_out_if.source  out_o
);
  import dfr_pkg::*;

  logic [CfgW-1:0] cfg_q;

  logic            s1_valid_q, s1_valid_d;
  logic            s1_cmd_q;
  logic [31:0]     s1_word_q;
  logic            s1_adv;

  logic            out_valid_q, out_valid_d;
  dfr_result_t     out_q;
  logic            out_free;

  logic            gen;
  dfr_result_t     res;

  // Configuration register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_i.valid) begin
      cfg_q <= cfg_i.samples_expected;
    end
  end

  // Event decode and state.
  dfr_core #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .samples_expected_i(cfg_q),
    .adv_i             (s1_adv),
    .cmd_i             (s1_cmd_q),
    .word_i            (s1_word_q),
    .gen_o             (gen),
    .res_o             (res)
  );

  // Pipeline flow: a beat leaves the input register unless its result
  // would land on a full, stalled output register.
  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_adv      = s1_valid_q && (out_free || !gen);
  assign in_i.ready  = !s1_valid_q || s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = in_i.valid;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && gen) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_cmd_q  <= in_i.cmd;
      s1_word_q <= in_i.word;
    end
    if (s1_adv && gen) begin
      out_q <= res;
    end
  end

  // Output channel.
  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_q.kind;
  assign out_o.sample_index   = out_q.sample_index;
  assign out_o.ch0_sample     = out_q.ch0_sample;
  assign out_o.ch1_sample     = out_q.ch1_sample;
  assign out_o.timestamp      = out_q.timestamp;
  assign out_o.internal_count = out_q.internal_count;
  assign out_o.event_number   = out_q.event_number;
  assign out_o.sample_count   = out_q.sample_count;
  assign out_o.quality_flag   = out_q.quality_flag;
  assign out_o.overflow       = out_q.overflow;

  `DFR_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q, "stalled beat was lost")
  `DFR_ASSERT_IMPL(a_drop_index, clk_i, rst_ni, out_valid_q && out_q.kind == KIND_SAMPLE && out_q.overflow, out_q.sample_index == 10'd0, "dropped word carries an index")

endmodule

`default_nettype wire
